// ----- rtl/core/typed_frame_deframer_crc8_defines.svh -----
// Assertion helpers for the deframer RTL.
`ifndef TYPED_FRAME_DEFRAMER_CRC8_DEFINES_SVH
`define TYPED_FRAME_DEFRAMER_CRC8_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define TFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/tfd_pkg.sv -----
`default_nettype none

package tfd_pkg;

  // Payload lengths of the fixed-size frame types.
  localparam int unsigned EncoderLen = 24;
  localparam int unsigned ImuLen     = 32;
  localparam int unsigned ShortLen   = 8;

  // Resync window length and the width of its position counter.
  localparam int unsigned SyncLen = 16;
  localparam int unsigned WinW    = $clog2(SyncLen);

  // Tick timer and configuration port widths.
  localparam int unsigned TimerW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [1:0] {
    KindByte   = 2'd0,
    KindGood   = 2'd1,
    KindError  = 2'd2,
    KindResync = 2'd3
  } out_kind_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrBadType = 2'd1,
    ErrTimeout = 2'd2,
    ErrBadCrc  = 2'd3
  } err_code_e;

  typedef enum logic [2:0] {
    MsgString    = 3'd0,
    MsgTimestamp = 3'd1,
    MsgEncoder   = 3'd2,
    MsgImu       = 3'd3,
    MsgMotor     = 3'd4
  } msg_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCodeNone      = 3'd0,
    RegCodeString    = 3'd1,
    RegCodeTimestamp = 3'd2,
    RegCodeEncoder   = 3'd3,
    RegCodeImu       = 3'd4,
    RegCodeMotor     = 3'd5,
    RegTimeout       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]        code_none;
    logic [7:0]        code_string;
    logic [7:0]        code_timestamp;
    logic [7:0]        code_encoder;
    logic [7:0]        code_imu;
    logic [7:0]        code_motor;
    logic [TimerW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] data;
    msg_kind_e  msg;
    err_code_e  err;
    logic [7:0] calc_crc;
    logic [7:0] recv_crc;
  } res_t;

  // CRC-8, polynomial 0x07, MSB first, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    end
    return c;
  endfunction

  // Index of the last payload byte of a fixed-size frame.
  function automatic logic [7:0] fixed_last(input msg_kind_e k);
    logic [7:0] last;
    case (k)
      MsgEncoder: last = 8'(EncoderLen - 1);
      MsgImu:     last = 8'(ImuLen - 1);
      default:    last = 8'(ShortLen - 1);
    endcase
    return last;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tfd_in_if.sv -----
`default_nettype none

interface tfd_in_if ();
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tfd_out_if.sv -----
`default_nettype none

interface tfd_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] msg_kind;
  logic [1:0] error_code;
  logic [7:0] calc_crc;
  logic [7:0] recv_crc;

  modport source (
    output valid, output out_kind, output out_byte, output msg_kind,
    output error_code, output calc_crc, output recv_crc, input ready
  );
  modport sink (
    input valid, input out_kind, input out_byte, input msg_kind,
    input error_code, input calc_crc, input recv_crc, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/tfd_cfg_if.sv -----
`default_nettype none

interface tfd_cfg_if import tfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tfd_cfg_regs.sv -----
`default_nettype none

module tfd_cfg_regs import tfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_idx_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; an index past the list is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        RegCodeNone:      cfg_d.code_none      = wr_data_i[7:0];
        RegCodeString:    cfg_d.code_string    = wr_data_i[7:0];
        RegCodeTimestamp: cfg_d.code_timestamp = wr_data_i[7:0];
        RegCodeEncoder:   cfg_d.code_encoder   = wr_data_i[7:0];
        RegCodeImu:       cfg_d.code_imu       = wr_data_i[7:0];
        RegCodeMotor:     cfg_d.code_motor     = wr_data_i[7:0];
        RegTimeout:       cfg_d.timeout_ticks  = wr_data_i[TimerW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_none      <= 8'd0;
      cfg_q.code_string    <= 8'd1;
      cfg_q.code_timestamp <= 8'd2;
      cfg_q.code_encoder   <= 8'd3;
      cfg_q.code_imu       <= 8'd4;
      cfg_q.code_motor     <= 8'd5;
      cfg_q.timeout_ticks  <= TimerW'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/tfd_step.sv -----
`default_nettype none

module tfd_step import tfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       mode_i,
  input  logic [7:0] data_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhString = 3'd1;
  localparam logic [2:0] PhFixed  = 3'd2;
  localparam logic [2:0] PhCrc    = 3'd3;
  localparam logic [2:0] PhResync = 3'd4;

  localparam logic [TimerW-1:0] TimerMax = '1;

  logic [2:0]        phase_q, phase_d;
  msg_kind_e         kind_q, kind_d;
  logic [7:0]        count_q, count_d;
  logic [7:0]        crc_q, crc_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [WinW-1:0]   win_pos_q, win_pos_d;
  logic              win_zero_q, win_zero_d;
  logic              zero_seen_q, zero_seen_d;
  err_code_e         cause_q, cause_d;

  logic              feed_zero, win_last, win_hit;
  logic [WinW-1:0]   win_pos_nx;
  logic              win_zero_nx;
  logic [7:0]        crc_nx;
  logic [TimerW-1:0] timer_inc;
  logic              timeout;
  logic              reading;

  // Aligned window tracker, fed with the current byte.
  assign feed_zero   = win_zero_q & (data_byte_i == 8'h00);
  assign win_last    = (win_pos_q == WinW'(SyncLen - 1));
  assign win_hit     = win_last & feed_zero;
  assign win_pos_nx  = win_last ? '0 : win_pos_q + 1'b1;
  assign win_zero_nx = win_last | feed_zero;

  assign crc_nx    = crc8_update(crc_q, data_byte_i);
  assign timer_inc = (timer_q == TimerMax) ? timer_q : timer_q + 1'b1;
  assign timeout   = (cfg_i.timeout_ticks != '0) && (timer_inc >= cfg_i.timeout_ticks);
  assign reading   = phase_q inside {PhString, PhFixed, PhCrc};

  // One event per call: next state and at most one result.
  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    count_d     = count_q;
    crc_d       = crc_q;
    timer_d     = timer_q;
    win_pos_d   = win_pos_q;
    win_zero_d  = win_zero_q;
    zero_seen_d = zero_seen_q;
    cause_d     = cause_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindByte, data: 8'h00, msg: MsgString, err: ErrNone,
                    calc_crc: 8'h00, recv_crc: 8'h00};

    if (mode_i) begin
      // Timer tick: only counts while a read phase is open.
      if (reading) begin
        timer_d = timer_inc;
        if (timeout) begin
          res_valid_o = 1'b1;
          if (phase_q == PhFixed && zero_seen_q) begin
            // The payload already held a clean window, so resync is over.
            phase_d     = PhIdle;
            win_pos_d   = '0;
            win_zero_d  = 1'b1;
            zero_seen_d = 1'b0;
            res_o.kind  = KindResync;
            res_o.err   = ErrTimeout;
          end else begin
            if (phase_q == PhFixed) begin
              zero_seen_d = 1'b0;
            end else begin
              win_pos_d   = '0;
              win_zero_d  = 1'b1;
              zero_seen_d = 1'b0;
            end
            cause_d    = ErrTimeout;
            phase_d    = PhResync;
            res_o.kind = KindError;
            res_o.msg  = kind_q;
            res_o.err  = ErrTimeout;
          end
        end
      end
    end else begin
      case (phase_q)
        PhIdle: begin
          if (data_byte_i != cfg_i.code_none) begin
            win_pos_d   = '0;
            win_zero_d  = 1'b1;
            zero_seen_d = 1'b0;
            crc_d       = 8'h00;
            count_d     = 8'h00;
            timer_d     = '0;
            phase_d     = PhFixed;
            if (data_byte_i == cfg_i.code_string) begin
              kind_d  = MsgString;
              phase_d = PhString;
            end else if (data_byte_i == cfg_i.code_timestamp) begin
              kind_d = MsgTimestamp;
            end else if (data_byte_i == cfg_i.code_encoder) begin
              kind_d = MsgEncoder;
            end else if (data_byte_i == cfg_i.code_imu) begin
              kind_d = MsgImu;
            end else if (data_byte_i == cfg_i.code_motor) begin
              kind_d = MsgMotor;
            end else begin
              // Unknown type: drop into resync with the CRC, count and timer untouched.
              kind_d      = MsgString;
              crc_d       = crc_q;
              count_d     = count_q;
              timer_d     = timer_q;
              cause_d     = ErrBadType;
              phase_d     = PhResync;
              res_valid_o = 1'b1;
              res_o.kind  = KindError;
              res_o.err   = ErrBadType;
            end
          end
        end

        PhString: begin
          crc_d       = crc_nx;
          timer_d     = '0;
          if (data_byte_i == 8'h00) begin
            phase_d = PhCrc;
          end
          res_valid_o = 1'b1;
          res_o.data  = data_byte_i;
          res_o.msg   = kind_q;
        end

        PhFixed: begin
          crc_d      = crc_nx;
          win_pos_d  = win_pos_nx;
          win_zero_d = win_zero_nx;
          if (win_hit) begin
            zero_seen_d = 1'b1;
          end
          count_d = count_q + 1'b1;
          if (count_q == fixed_last(kind_q)) begin
            phase_d = PhCrc;
            timer_d = '0;
          end
          res_valid_o = 1'b1;
          res_o.data  = data_byte_i;
          res_o.msg   = kind_q;
        end

        PhCrc: begin
          res_valid_o    = 1'b1;
          res_o.msg      = kind_q;
          res_o.calc_crc = crc_q;
          res_o.recv_crc = data_byte_i;
          if (data_byte_i == crc_q) begin
            phase_d    = PhIdle;
            res_o.kind = KindGood;
          end else begin
            win_pos_d   = '0;
            win_zero_d  = 1'b1;
            zero_seen_d = 1'b0;
            cause_d     = ErrBadCrc;
            phase_d     = PhResync;
            res_o.kind  = KindError;
            res_o.err   = ErrBadCrc;
          end
        end

        PhResync: begin
          win_pos_d  = win_pos_nx;
          win_zero_d = win_zero_nx;
          if (win_hit) begin
            phase_d     = PhIdle;
            win_pos_d   = '0;
            win_zero_d  = 1'b1;
            zero_seen_d = 1'b0;
            res_valid_o = 1'b1;
            res_o.kind  = KindResync;
            res_o.err   = cause_q;
          end
        end

        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // Frame state advances only when an event is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      kind_q      <= MsgString;
      count_q     <= 8'h00;
      crc_q       <= 8'h00;
      timer_q     <= '0;
      win_pos_q   <= '0;
      win_zero_q  <= 1'b1;
      zero_seen_q <= 1'b0;
      cause_q     <= ErrNone;
    end else if (step_i) begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
      timer_q     <= timer_d;
      win_pos_q   <= win_pos_d;
      win_zero_q  <= win_zero_d;
      zero_seen_q <= zero_seen_d;
      cause_q     <= cause_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tfd_out_reg.sv -----
`default_nettype none

module tfd_out_reg import tfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  // Hold a result until the receiver completes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/typed_frame_deframer_crc8.sv -----
// Receive-side deframer for a typed byte-serial link with a CRC-8 check.
// Input channel in_i: one event per transfer, mode 0 carries a received
// byte in data_byte, mode 1 is one timer tick. Output channel out_o: at
// most one result per event (payload byte, frame good, frame error or
// resync done). Configuration channel cfg_i: register index and data; it
// is always ready. The user must write it only while no event is in flight;
// the block itself does not enforce this. An accepted event is held in the
// input register and is decoded into the output register, which drives
// out_o, once the output side has room. While out_o is not stalled, one
// event is taken every cycle; the frame state update and the byte-wide CRC
// step both sit between the input and output registers. When out_o is
// stalled the output register holds its result, the input register keeps
// one more event, and in_i.ready drops only then. Reset clears the frame
// state to waiting for a type byte and loads the default type codes and a
// timeout of 100 ticks.
`default_nettype none

`include "typed_frame_deframer_crc8_defines.svh"

module typed_frame_deframer_crc8 import tfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  tfd_in_if.sink     in_i,
  tfd_out_if.source  out_o,
  tfd_cfg_if.sink    cfg_i
);

  logic       in_valid_q;
  logic       in_mode_q;
  logic [7:0] in_byte_q;
  logic       in_xfer;
  logic       step;
  logic       res_valid;
  res_t       res_step;
  res_t       res_out;
  cfg_t       cfg;
  logic       resync_shown;
  logic       resync_clean;

  // The event in the input register moves on when the output side has room.
  assign step     = in_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !in_valid_q || step;
  assign in_xfer  = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_mode_q <= in_i.mode;
      in_byte_q <= in_i.data_byte;
    end
  end

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  tfd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // Frame decoder.
  tfd_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .mode_i      (in_mode_q),
    .data_byte_i (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res_step)
  );

  // Result register.
  tfd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res_step),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .res_o   (res_out)
  );

  assign out_o.out_kind   = res_out.kind;
  assign out_o.out_byte   = res_out.data;
  assign out_o.msg_kind   = res_out.msg;
  assign out_o.error_code = res_out.err;
  assign out_o.calc_crc   = res_out.calc_crc;
  assign out_o.recv_crc   = res_out.recv_crc;

  // Terms of the resync result check.
  assign resync_shown = out_o.valid && (out_o.out_kind == KindResync);
  assign resync_clean = (out_o.msg_kind == MsgString) && (out_o.error_code != ErrNone);

  // An empty input register always takes a new event.
  `TFD_ASSERT(a_in_ready_when_empty, !in_valid_q |-> in_i.ready, "input stalled while empty")

  // A pending result is never overwritten by the decoder.
  `TFD_ASSERT(a_no_overwrite, (out_o.valid && !out_o.ready) |-> !step, "result overwritten")

  // Resync done never carries a frame kind and always carries its cause.
  `TFD_ASSERT(a_resync_fields, resync_shown |-> resync_clean, "bad resync result")

endmodule

`default_nettype wire

// ----- tb/typed_frame_deframer_crc8_tb.sv -----
`timescale 1ns / 100ps

module typed_frame_deframer_crc8_tb;
  import tfd_pkg::*;

  localparam int unsigned IdlePct       = 29;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHold      = 300;

  typedef enum logic [2:0] {
    PhIdle,
    PhString,
    PhFixed,
    PhCrc,
    PhResync
  } rx_phase_e;

  typedef struct packed {
    rx_phase_e         phase;
    msg_kind_e         kind;
    logic [7:0]        count;
    logic [7:0]        crc;
    logic [TimerW-1:0] timer;
    logic [7:0]        win_pos;
    logic              win_zero;
    logic              zero_win_seen;
    err_code_e         cause;
  } rx_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } rx_event_t;

  logic clk_i;
  logic rst_ni;

  tfd_in_if  in_if ();
  tfd_out_if out_if ();
  tfd_cfg_if cfg_if ();

  typed_frame_deframer_crc8 u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Stimulus and prediction state.
  cfg_t        active_cfg;
  rx_state_t   stim_state;
  rx_state_t   pred_state;
  rx_event_t   rx_pending[$];
  res_t        expected_results[$];
  logic        frame_zero_heavy = 1'b0;
  logic        in_took = 1'b0;
  int unsigned in_accepted = 0;
  int unsigned out_hold = 0;
  logic        long_hold_done = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bitwise CRC-8 with polynomial 0x07, data MSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_len(input msg_kind_e k);
    case (k)
      MsgEncoder: return 8'(EncoderLen);
      MsgImu:     return 8'(ImuLen);
      default:    return 8'(ShortLen);
    endcase
  endfunction

  function automatic res_t make_res(input out_kind_e kind, input logic [7:0] data,
                                    input msg_kind_e msg, input err_code_e err,
                                    input logic [7:0] cc, input logic [7:0] rc);
    res_t r;
    r.kind     = kind;
    r.data     = data;
    r.msg      = msg;
    r.err      = err;
    r.calc_crc = cc;
    r.recv_crc = rc;
    return r;
  endfunction

  function automatic cfg_t make_cfg(input logic [7:0] none, input logic [7:0] str,
                                    input logic [7:0] ts, input logic [7:0] enc,
                                    input logic [7:0] imu, input logic [7:0] mot,
                                    input logic [TimerW-1:0] ticks);
    cfg_t c;
    c.code_none      = none;
    c.code_string    = str;
    c.code_timestamp = ts;
    c.code_encoder   = enc;
    c.code_imu       = imu;
    c.code_motor     = mot;
    c.timeout_ticks  = ticks;
    return c;
  endfunction

  function automatic rx_state_t idle_state();
    rx_state_t st;
    st.phase         = PhIdle;
    st.kind          = MsgString;
    st.count         = '0;
    st.crc           = '0;
    st.timer         = '0;
    st.win_pos       = '0;
    st.win_zero      = 1'b1;
    st.zero_win_seen = 1'b0;
    st.cause         = ErrNone;
    return st;
  endfunction

  function automatic void clear_window(inout rx_state_t st);
    st.win_pos       = '0;
    st.win_zero      = 1'b1;
    st.zero_win_seen = 1'b0;
  endfunction

  // Adds one byte to the aligned resync window; true when an all-zero window closes.
  function automatic logic window_push(inout rx_state_t st, input logic [7:0] b);
    logic closed_zero;
    closed_zero = 1'b0;
    if (b != 8'h00) st.win_zero = 1'b0;
    st.win_pos = st.win_pos + 8'd1;
    if (st.win_pos >= SyncLen) begin
      closed_zero = st.win_zero;
      st.win_pos  = '0;
      st.win_zero = 1'b1;
    end
    return closed_zero;
  endfunction

  // Advances the deframer state by one event; returns 1 when a result is produced.
  function automatic logic deframe_step(inout rx_state_t st, input cfg_t c,
                                        input rx_event_t ev, output res_t r);
    logic [7:0] b;
    b = ev.data;
    r = make_res(KindByte, 8'h00, MsgString, ErrNone, 8'h00, 8'h00);

    // Timer ticks only matter while a payload or CRC is being read.
    if (ev.mode) begin
      if (st.phase != PhString && st.phase != PhFixed && st.phase != PhCrc) return 1'b0;
      if (st.timer != '1) st.timer = st.timer + 1'b1;
      if (c.timeout_ticks == '0 || st.timer < c.timeout_ticks) return 1'b0;
      if (st.phase == PhFixed && st.zero_win_seen) begin
        st.phase = PhIdle;
        clear_window(st);
        r = make_res(KindResync, 8'h00, MsgString, ErrTimeout, 8'h00, 8'h00);
        return 1'b1;
      end
      // A cut fixed field keeps its partial window; other reads resync from empty.
      if (st.phase == PhFixed) st.zero_win_seen = 1'b0;
      else clear_window(st);
      st.cause = ErrTimeout;
      st.phase = PhResync;
      r = make_res(KindError, 8'h00, st.kind, ErrTimeout, 8'h00, 8'h00);
      return 1'b1;
    end

    case (st.phase)
      PhIdle: begin
        if (b == c.code_none) return 1'b0;
        if (b == c.code_string) st.kind = MsgString;
        else if (b == c.code_timestamp) st.kind = MsgTimestamp;
        else if (b == c.code_encoder) st.kind = MsgEncoder;
        else if (b == c.code_imu) st.kind = MsgImu;
        else if (b == c.code_motor) st.kind = MsgMotor;
        else begin
          st.kind = MsgString;
          clear_window(st);
          st.cause = ErrBadType;
          st.phase = PhResync;
          r = make_res(KindError, 8'h00, MsgString, ErrBadType, 8'h00, 8'h00);
          return 1'b1;
        end
        st.crc   = '0;
        st.count = '0;
        st.timer = '0;
        clear_window(st);
        st.phase = (st.kind == MsgString) ? PhString : PhFixed;
        return 1'b0;
      end
      PhString: begin
        st.crc   = crc8_next(st.crc, b);
        st.timer = '0;
        if (b == 8'h00) st.phase = PhCrc;
        r = make_res(KindByte, b, st.kind, ErrNone, 8'h00, 8'h00);
        return 1'b1;
      end
      PhFixed: begin
        st.crc = crc8_next(st.crc, b);
        if (window_push(st, b)) st.zero_win_seen = 1'b1;
        st.count = st.count + 8'd1;
        if (st.count >= frame_len(st.kind)) begin
          st.phase = PhCrc;
          st.timer = '0;
        end
        r = make_res(KindByte, b, st.kind, ErrNone, 8'h00, 8'h00);
        return 1'b1;
      end
      PhCrc: begin
        if (b == st.crc) begin
          st.phase = PhIdle;
          r = make_res(KindGood, 8'h00, st.kind, ErrNone, st.crc, b);
          return 1'b1;
        end
        clear_window(st);
        st.cause = ErrBadCrc;
        st.phase = PhResync;
        r = make_res(KindError, 8'h00, st.kind, ErrBadCrc, st.crc, b);
        return 1'b1;
      end
      PhResync: begin
        if (window_push(st, b)) begin
          st.phase = PhIdle;
          clear_window(st);
          r = make_res(KindResync, 8'h00, MsgString, st.cause, 8'h00, 8'h00);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        st.phase = PhIdle;
        return 1'b0;
      end
    endcase
  endfunction

  // Queues one event and tracks where the stream leaves the block.
  task automatic push_event(input logic mode, input logic [7:0] data);
    rx_event_t ev;
    res_t      ignored;
    ev.mode = mode;
    ev.data = data;
    void'(deframe_step(stim_state, active_cfg, ev, ignored));
    rx_pending = {rx_pending, ev};
  endtask

  // Picks the next event from the tracked phase: mostly well-formed frames.
  task automatic gen_event();
    int unsigned roll;
    logic [7:0]  code;
    roll = $urandom_range(0, 99);
    case (stim_state.phase)
      PhIdle: begin
        if (roll < 65) begin
          frame_zero_heavy = ($urandom_range(0, 3) == 0);
          case ($urandom_range(0, 4))
            0:       code = active_cfg.code_string;
            1:       code = active_cfg.code_timestamp;
            2:       code = active_cfg.code_encoder;
            3:       code = active_cfg.code_imu;
            default: code = active_cfg.code_motor;
          endcase
          push_event(1'b0, code);
        end else if (roll < 75) begin
          push_event(1'b0, active_cfg.code_none);
        end else if (roll < 80) begin
          push_event(1'b1, 8'($urandom_range(0, 255)));
        end else begin
          push_event(1'b0, 8'($urandom_range(0, 255)));
        end
      end
      PhString, PhFixed, PhCrc: begin
        if (roll < 5) begin
          push_event(1'b1, 8'($urandom_range(0, 255)));
        end else if (roll < 6 && active_cfg.timeout_ticks != '0 &&
                     active_cfg.timeout_ticks <= 64) begin
          repeat (active_cfg.timeout_ticks) push_event(1'b1, 8'($urandom_range(0, 255)));
        end else if (stim_state.phase == PhString) begin
          if ($urandom_range(0, 5) == 0) push_event(1'b0, 8'h00);
          else push_event(1'b0, 8'($urandom_range(1, 255)));
        end else if (stim_state.phase == PhFixed) begin
          if (frame_zero_heavy && roll < 80) push_event(1'b0, 8'h00);
          else push_event(1'b0, 8'($urandom_range(0, 255)));
        end else if (roll < 90) begin
          push_event(1'b0, stim_state.crc);
        end else if (roll < 96) begin
          push_event(1'b0, stim_state.crc ^ 8'($urandom_range(1, 255)));
        end else begin
          push_event(1'b0, 8'($urandom_range(0, 255)));
        end
      end
      default: begin
        if (roll < 5) push_event(1'b1, 8'($urandom_range(0, 255)));
        else if (roll < 85) push_event(1'b0, 8'h00);
        else push_event(1'b0, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Random events, then enough more to leave the stream between frames.
  task automatic run_random(input int unsigned count);
    repeat (count) gen_event();
    while (stim_state.phase != PhIdle) gen_event();
  endtask

  // Writes every register through the configuration channel.
  task automatic apply_cfg(input cfg_t c);
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] val;
    for (int i = 0; i <= int'(RegTimeout); i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        RegCodeNone:      val = CfgDataW'(c.code_none);
        RegCodeString:    val = CfgDataW'(c.code_string);
        RegCodeTimestamp: val = CfgDataW'(c.code_timestamp);
        RegCodeEncoder:   val = CfgDataW'(c.code_encoder);
        RegCodeImu:       val = CfgDataW'(c.code_imu);
        RegCodeMotor:     val = CfgDataW'(c.code_motor);
        RegTimeout:       val = c.timeout_ticks;
        default:          val = '0;
      endcase
      @(negedge clk_i);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= val;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    active_cfg = c;
  endtask

  // Sender holds off until every queued event is taken and every result is back.
  task automatic drain();
    while (rx_pending.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic calm_window();
    return in_accepted >= 700 && in_accepted < 950;
  endfunction

  // Input driver: a new event may go out at the falling edge after a transfer or while idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_took)) begin
      if (rx_pending.size() != 0 && (calm_window() || $urandom_range(0, 99) >= IdlePct)) begin
        in_if.valid     <= 1'b1;
        in_if.mode      <= rx_pending[0].mode;
        in_if.data_byte <= rx_pending[0].data;
        void'(rx_pending.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Each input transfer updates the prediction.
  always @(posedge clk_i) begin : input_accept
    rx_event_t ev;
    res_t      r;
    if (rst_ni) begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        ev.mode = in_if.mode;
        ev.data = in_if.data_byte;
        if (deframe_step(pred_state, active_cfg, ev, r)) expected_results = {expected_results, r};
        in_accepted = in_accepted + 1;
      end
    end
  end

  // Output ready: random stalls plus one long hold while the sender keeps going.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && in_accepted >= 350) begin
        long_hold_done = 1'b1;
        out_hold = LongHold;
      end
      if (out_hold != 0) begin
        out_hold = out_hold - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm_window() || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor: compares each output transfer with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: out_kind %0d", out_if.out_kind);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_kind", 8'(want.kind), 8'(out_if.out_kind));
        check_field("out_byte", want.data, out_if.out_byte);
        check_field("msg_kind", 8'(want.msg), 8'(out_if.msg_kind));
        check_field("error_code", 8'(want.err), 8'(out_if.error_code));
        check_field("calc_crc", want.calc_crc, out_if.calc_crc);
        check_field("recv_crc", want.recv_crc, out_if.recv_crc);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Reset, configuration phases and stimulus.
  initial begin : stimulus
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = 1'b0;
    in_if.data_byte = 8'h00;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegCodeNone;
    cfg_if.data     = '0;
    stim_state      = idle_state();
    pred_state      = idle_state();
    active_cfg      = make_cfg(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, TimerW'(100));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default codes with a short timeout for the directed frames.
    apply_cfg(make_cfg(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, TimerW'(2)));
    // A tick while waiting for a type is ignored, as is a filler byte.
    push_event(1'b1, 8'hFF);
    push_event(1'b0, 8'h00);
    // String frame with extreme payload bytes and its terminator.
    push_event(1'b0, 8'h01);
    push_event(1'b0, 8'hFF);
    push_event(1'b0, 8'h00);
    push_event(1'b0, stim_state.crc);
    // Fixed field cut by a timeout after a complete all-zero window.
    push_event(1'b0, 8'h04);
    repeat (SyncLen) push_event(1'b0, 8'h00);
    push_event(1'b1, 8'h00);
    push_event(1'b1, 8'hA5);
    // Unknown type code enters resync; the random part carries on from there.
    push_event(1'b0, 8'h07);
    run_random(200);
    drain();

    // Extreme codes and the shortest timeout.
    apply_cfg(make_cfg(8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, TimerW'(1)));
    run_random(250);
    drain();

    // Colliding type codes; timeout disabled.
    apply_cfg(make_cfg(8'h00, 8'h10, 8'h10, 8'h20, 8'h30, 8'h30, TimerW'(0)));
    run_random(250);
    drain();

    // Random codes with the longest timeout.
    apply_cfg(make_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), '1));
    run_random(200);
    drain();

    // Random codes with a random short timeout.
    apply_cfg(make_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       TimerW'($urandom_range(2, 40))));
    run_random(300);
    drain();

    // Back to the reset settings.
    apply_cfg(make_cfg(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, TimerW'(100)));
    run_random(200);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
